// File: rtl/bfgr_pkg.sv
package bfgr_pkg;

    localparam int MAX_GLYPHS      = 512;
    localparam int MAX_GLYPH_ROWS  = 16;
    localparam int MAX_GLYPH_WIDTH = 16;

    localparam int STORE_DEPTH = MAX_GLYPHS * MAX_GLYPH_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int GLYPH_W     = $clog2(MAX_GLYPHS);
    localparam int ROW_W       = $clog2(MAX_GLYPH_ROWS);
    localparam int ROWCNT_W    = $clog2(MAX_GLYPH_ROWS + 1);

    localparam int FONT_W      = 16;
    localparam int CODE_W      = 16;
    localparam int POS_W       = 16;
    localparam int COLOR_W     = 32;
    localparam int OFFSET_W    = 32;
    localparam int DIM_W       = 5;
    localparam int COUNT_W     = 10;
    localparam int PITCH_W     = 16;

    localparam int BPP_SHIFT   = 2;   // 4 bytes per pixel

    localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 80;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    typedef enum logic [1:0] {
        KIND_FONT   = 2'd0,
        KIND_CURSOR = 2'd1,
        KIND_AT     = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_GLYPH_WIDTH  = 3'd0,
        REG_GLYPH_HEIGHT = 3'd1,
        REG_GLYPH_COUNT  = 3'd2,
        REG_LINE_PITCH   = 3'd3,
        REG_TEXT_COLOR   = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PROD,
        ST_BASE,
        ST_ROWS
    } state_t;

    typedef struct packed {
        logic                last;
        logic [COLOR_W-1:0]  color;
        logic [FONT_W-1:0]   bits;
        logic [OFFSET_W-1:0] offset;
    } beat_t;

    function automatic logic [DIM_W-1:0] sat_dim(logic [DIM_W-1:0] v, int lim);
        logic [DIM_W-1:0] r;
        r = (int'(v) > lim) ? DIM_W'(lim) : v;
        return r;
    endfunction

endpackage

// File: rtl/bitmap_font_glyph_renderer_unit.sv
// Channel   Dir   Handshake              Contents
// s_*       in    s_tvalid / s_tready    font write or character item
// m_*       out   m_tvalid / m_tready    one glyph row per transaction
// apb       in    psel & penable         configuration registers
//
// Character: setup states SCALE, PROD and BASE, then one row per cycle while the
// output does not stall (glyph height rows), set by the single font RAM read port.
// Reset clears control, cursor and registers; font RAM holds no reset value.
// Output stall holds the row reads; a 2-entry output stage keeps one row/cycle.
// Next item accepted once the last row read is issued.
module bitmap_font_glyph_renderer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // char_code[15:0] col[31:16] line_index[47:32] draw_color[79:48]
    // font_addr[92:80] font_bits[108:93] zero[111:109]
    input  logic [bfgr_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_offset[31:0] row_bits[47:32] pixel_color[79:48]
    output logic [bfgr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfgr_pkg::PADDR_W-1:0]        paddr,
    input  logic [bfgr_pkg::PDATA_W-1:0]        pwdata,
    output logic [bfgr_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import bfgr_pkg::*;

    // configuration
    logic [DIM_W-1:0]   glyph_width_reg;
    logic [DIM_W-1:0]   glyph_height_reg;
    logic [COUNT_W-1:0] glyph_count_reg;
    logic [PITCH_W-1:0] line_pitch_reg;
    logic [COLOR_W-1:0] text_color_reg;

    // cursor
    logic [POS_W-1:0]   cursor_col_reg;
    logic [POS_W-1:0]   cursor_row_reg;

    // item
    state_t               state_reg;
    state_t               state_next;
    logic [GLYPH_W-1:0]   glyph_reg;
    logic [POS_W-1:0]     x_reg;
    logic [POS_W-1:0]     y_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic [FONT_W-1:0]    wmask_reg;
    logic [POS_W+DIM_W-1:0] yh_reg;
    logic [POS_W+DIM_W-1:0] xw_reg;
    logic [OFFSET_W-1:0]  prod_reg;
    logic [OFFSET_W-1:0]  off_reg;
    logic [ROWCNT_W-1:0]  row_cnt_reg;

    // read and output stage
    logic                 rd_v_reg;
    logic [FONT_W-1:0]    rd_data_reg;
    logic [OFFSET_W-1:0]  rd_off_reg;
    logic                 rd_last_reg;
    beat_t                out_reg;
    logic                 out_v_reg;
    beat_t                skid_reg;
    logic                 skid_v_reg;

    logic [FONT_W-1:0]    font_mem [STORE_DEPTH];

    logic                 cfg_we;
    reg_idx_t             cfg_idx;
    logic                 s_acc;
    kind_t                kind;
    logic [CODE_W-1:0]    char_code;
    logic [POS_W-1:0]     in_col;
    logic [POS_W-1:0]     in_line;
    logic [COLOR_W-1:0]   in_color;
    logic [ADDR_W-1:0]    in_font_addr;
    logic [FONT_W-1:0]    in_font_bits;
    logic                 font_we;
    logic                 is_newline;
    logic                 render_start;
    logic [GLYPH_W-1:0]   glyph_sel;
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic                 pop;
    logic [1:0]           occ_after;
    logic                 rd_issue;
    logic                 rd_last;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rows_done;
    beat_t                rd_beat;

    assign kind         = kind_t'(s_tuser);
    assign char_code    = s_tdata[15:0];
    assign in_col       = s_tdata[31:16];
    assign in_line      = s_tdata[47:32];
    assign in_color     = s_tdata[79:48];
    assign in_font_addr = s_tdata[92:80];
    assign in_font_bits = s_tdata[108:93];

    assign w_eff = sat_dim(glyph_width_reg, MAX_GLYPH_WIDTH);
    assign h_eff = sat_dim(glyph_height_reg, MAX_GLYPH_ROWS);

    assign s_acc        = s_tvalid && s_tready;
    assign is_newline   = (char_code == NEWLINE_CODE);
    assign font_we      = s_acc && (kind == KIND_FONT);
    assign render_start = s_acc && ((kind == KIND_AT) || (kind == KIND_CURSOR && !is_newline));
    assign glyph_sel    = (char_code != '0 && char_code < CODE_W'(glyph_count_reg))
                          ? char_code[GLYPH_W-1:0] : '0;

    assign pop       = m_tvalid && m_tready;
    assign occ_after = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(rd_v_reg) - 2'(pop);
    assign rd_last   = (ROWCNT_W'(row_cnt_reg + 1'b1) == ROWCNT_W'(h_eff));
    assign rows_done = (row_cnt_reg >= ROWCNT_W'(h_eff));
    assign rd_addr   = {glyph_reg, row_cnt_reg[ROW_W-1:0]};

    assign rd_beat.offset = rd_off_reg;
    assign rd_beat.bits   = rd_data_reg & wmask_reg;
    assign rd_beat.color  = color_reg;
    assign rd_beat.last   = rd_last_reg;

    // APB
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_GLYPH_WIDTH:  prdata = PDATA_W'(glyph_width_reg);
            REG_GLYPH_HEIGHT: prdata = PDATA_W'(glyph_height_reg);
            REG_GLYPH_COUNT:  prdata = PDATA_W'(glyph_count_reg);
            REG_LINE_PITCH:   prdata = PDATA_W'(line_pitch_reg);
            REG_TEXT_COLOR:   prdata = text_color_reg;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg  <= DIM_W'(8);
            glyph_height_reg <= DIM_W'(16);
            glyph_count_reg  <= COUNT_W'(256);
            line_pitch_reg   <= PITCH_W'(4096);
            text_color_reg   <= COLOR_W'(32'h00FF_FFFF);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_GLYPH_WIDTH:  glyph_width_reg  <= pwdata[DIM_W-1:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= pwdata[DIM_W-1:0];
                REG_GLYPH_COUNT:  glyph_count_reg  <= pwdata[COUNT_W-1:0];
                REG_LINE_PITCH:   line_pitch_reg   <= pwdata[PITCH_W-1:0];
                REG_TEXT_COLOR:   text_color_reg   <= pwdata;
                default:          ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (render_start) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_PROD;
            ST_PROD:  state_next = ST_BASE;
            ST_BASE:  state_next = ST_ROWS;
            ST_ROWS:  if (rows_done || (rd_issue && rd_last)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_issue = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_ROWS:  rd_issue = !rows_done && (occ_after <= 2'd1);
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_acc && kind == KIND_CURSOR)
            begin
                if (is_newline)
                begin
                    cursor_row_reg <= cursor_row_reg + 1'b1;
                    cursor_col_reg <= '0;
                end
                else
                begin
                    cursor_col_reg <= cursor_col_reg + 1'b1;
                end
            end
        end
    end

    // item datapath: y*h and x*w, then (y*h)*pitch, then base offset
    always_ff @(posedge clk)
    begin
        if (render_start)
        begin
            glyph_reg <= glyph_sel;
            wmask_reg <= FONT_W'((17'(1) << w_eff) - 17'(1));
            if (kind == KIND_AT)
            begin
                x_reg     <= in_col;
                y_reg     <= in_line;
                color_reg <= in_color;
            end
            else
            begin
                x_reg     <= cursor_col_reg;
                y_reg     <= cursor_row_reg;
                color_reg <= text_color_reg;
            end
        end
        if (state_reg == ST_SCALE)
        begin
            yh_reg <= y_reg * h_eff;
            xw_reg <= x_reg * w_eff;
        end
        if (state_reg == ST_PROD)
        begin
            prod_reg <= OFFSET_W'(yh_reg) * OFFSET_W'(line_pitch_reg);
        end
        if (state_reg == ST_BASE)
        begin
            off_reg <= prod_reg + OFFSET_W'({xw_reg, {BPP_SHIFT{1'b0}}});
        end
        else if (rd_issue)
        begin
            off_reg <= off_reg + OFFSET_W'(line_pitch_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
        end
        else if (state_reg == ST_BASE)
        begin
            row_cnt_reg <= '0;
        end
        else if (rd_issue)
        begin
            row_cnt_reg <= row_cnt_reg + 1'b1;
        end
    end

    // font RAM: writes only while idle, reads only while rendering
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[in_font_addr] <= in_font_bits;
        end
        if (rd_issue)
        begin
            rd_data_reg <= font_mem[rd_addr];
            rd_off_reg  <= off_reg;
            rd_last_reg <= rd_last;
        end
    end

    // output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= rd_issue;
            if (!out_v_reg || pop)
            begin
                if (skid_v_reg)
                begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= rd_v_reg;
                end
                else
                begin
                    out_v_reg <= rd_v_reg;
                end
            end
            else if (rd_v_reg)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                out_reg <= skid_reg;
                if (rd_v_reg)
                begin
                    skid_reg <= rd_beat;
                end
            end
            else if (rd_v_reg)
            begin
                out_reg <= rd_beat;
            end
        end
        else if (rd_v_reg)
        begin
            skid_reg <= rd_beat;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.color, out_reg.bits, out_reg.offset};
    assign m_tlast  = out_reg.last;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry valid with empty output register");

    a_read_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> !skid_v_reg)
        else $error("font read returns with no free output entry");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROWS) |-> (row_cnt_reg <= ROWCNT_W'(h_eff)))
        else $error("row counter past glyph height");

    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rd_issue |-> !font_we)
        else $error("font write during glyph read");

endmodule

// File: verif/bitmap_font_glyph_renderer_unit_test.sv
module bitmap_font_glyph_renderer_unit_test;
    import bfgr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] font_bits;
        logic [12:0] font_addr;
        logic [31:0] draw_color;
        logic [15:0] line_index;
        logic [15:0] col;
        logic [15:0] char_code;
    } char_item_t;

    class glyph_row_tracker;
        logic [FONT_W-1:0] font_ram [0:STORE_DEPTH-1];
        logic [15:0]       cur_col;
        logic [15:0]       cur_row;
        logic [4:0]        width_r;
        logic [4:0]        height_r;
        logic [9:0]        count_r;
        logic [15:0]       pitch_r;
        logic [31:0]       color_r;
        beat_t             rows_due[$];
        int                errors;

        function new();
            cur_col  = '0;
            cur_row  = '0;
            width_r  = 5'd8;
            height_r = 5'd16;
            count_r  = 10'd256;
            pitch_r  = 16'd4096;
            color_r  = 32'h00FF_FFFF;
            errors   = 0;
        endfunction

        task report(string msg);
            if (errors < 30)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (reg_idx_t'(idx))
                REG_GLYPH_WIDTH:  width_r  = v[4:0];
                REG_GLYPH_HEIGHT: height_r = v[4:0];
                REG_GLYPH_COUNT:  count_r  = v[9:0];
                REG_LINE_PITCH:   pitch_r  = v[15:0];
                REG_TEXT_COLOR:   color_r  = v;
                default: ;
            endcase
        endfunction

        function void draw_glyph(logic [15:0] code, logic [15:0] x, logic [15:0] y,
                                 logic [31:0] color);
            int unsigned w;
            int unsigned h;
            int unsigned g;
            logic [15:0] wmask;
            logic [63:0] base;
            logic [12:0] addr;
            beat_t       row;
            w = (width_r > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : width_r;
            h = (height_r > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : height_r;
            g = (code > 0 && code < count_r) ? code : 0;
            wmask = (w >= 16) ? 16'hFFFF : 16'((32'd1 << w) - 1);
            base = 64'(y) * 64'(h) * 64'(pitch_r) + 64'(x) * 64'(w) * 64'd4;
            for (int unsigned r = 0; r < h; r++)
            begin
                addr       = 13'(g * MAX_GLYPH_ROWS + r);
                row.offset = 32'(base + 64'(r) * 64'(pitch_r));
                row.bits   = font_ram[addr] & wmask;
                row.color  = color;
                row.last   = (r + 1 == h);
                rows_due.push_back(row);
            end
        endfunction

        function void take_item(kind_t k, char_item_t it);
            case (k)
                KIND_FONT:
                begin
                    font_ram[it.font_addr] = it.font_bits;
                end
                KIND_CURSOR:
                begin
                    if (it.char_code == NEWLINE_CODE)
                    begin
                        cur_row = cur_row + 16'd1;
                        cur_col = '0;
                    end
                    else
                    begin
                        draw_glyph(it.char_code, cur_col, cur_row, color_r);
                        cur_col = cur_col + 16'd1;
                    end
                end
                KIND_AT:
                    draw_glyph(it.char_code, it.col, it.line_index, it.draw_color);
                default: ;
            endcase
        endfunction

        task check_row(beat_t got);
            beat_t want;
            if (rows_due.size() == 0)
            begin
                report($sformatf("unexpected row offset %h bits %h color %h last %b",
                                 got.offset, got.bits, got.color, got.last));
                return;
            end
            want = rows_due.pop_front();
            if (got.offset !== want.offset)
                report($sformatf("pixel_offset got %h want %h", got.offset, want.offset));
            if (got.bits !== want.bits)
                report($sformatf("row_bits got %h want %h (offset %h)",
                                 got.bits, want.bits, want.offset));
            if (got.color !== want.color)
                report($sformatf("pixel_color got %h want %h (offset %h)",
                                 got.color, want.color, want.offset));
            if (got.last !== want.last)
                report($sformatf("last got %b want %b (offset %h)",
                                 got.last, want.last, want.offset));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    glyph_row_tracker trk;
    int               idle_cycles;
    bit               moved;
    int               items_sent;
    int               burst_left;
    int               stall_pct;
    int               stall_left;
    int               ready_glyphs[$];

    bitmap_font_glyph_renderer_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                trk.take_item(kind_t'(s_tuser), char_item_t'(s_tdata));
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                trk.check_row(beat_t'({m_tlast, m_tdata}));
                moved = 1'b1;
            end
            if (psel && penable && pwrite && pready)
            begin
                trk.set_reg(paddr[4:2], pwdata);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 12);
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("bitmap_font_glyph_renderer_unit verification failed");
        $finish;
    end

    function automatic char_item_t noise_item();
        char_item_t it;
        it.pad        = '0;
        it.font_bits  = 16'($urandom);
        it.font_addr  = 13'($urandom);
        it.draw_color = $urandom;
        it.line_index = 16'($urandom);
        it.col        = 16'($urandom);
        it.char_code  = 16'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] rand_bits();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(32'd1 << $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_pos();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 7));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_color();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // only codes whose selected glyph has every row loaded
    function automatic logic [15:0] pick_code();
        int g;
        g = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
        if (g != 0 && g < trk.count_r)
            return 16'(g);
        if ($urandom_range(0, 2) == 0)
            return 16'h0000;
        return 16'($urandom_range(65535, trk.count_r));
    endfunction

    task automatic push_item(kind_t k, char_item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= it;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (k != KIND_NONE)
            items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic put_font(logic [12:0] addr, logic [15:0] bits);
        char_item_t it;
        it = noise_item();
        it.font_addr = addr;
        it.font_bits = bits;
        push_item(KIND_FONT, it);
    endtask

    task automatic put_char(kind_t k, logic [15:0] code, logic [15:0] x, logic [15:0] y,
                            logic [31:0] color);
        char_item_t it;
        it = noise_item();
        it.char_code  = code;
        it.col        = x;
        it.line_index = y;
        it.draw_color = color;
        push_item(k, it);
    endtask

    task automatic load_glyph(int g);
        for (int r = 0; r < MAX_GLYPH_ROWS; r++)
            put_font(13'(g * MAX_GLYPH_ROWS + r), rand_bits());
        ready_glyphs.push_back(g);
    endtask

    task automatic wait_rows_done();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (trk.rows_due.size() != 0);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(int w, int h, int cnt, int pitch, logic [31:0] color);
        wait_rows_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_GLYPH_WIDTH, 32'(w));
        write_reg(REG_GLYPH_HEIGHT, 32'(h));
        write_reg(REG_GLYPH_COUNT, 32'(cnt));
        write_reg(REG_LINE_PITCH, 32'(pitch));
        write_reg(REG_TEXT_COLOR, color);
        stall_pct = $urandom_range(0, 3) * 20;
    endtask

    task automatic random_item();
        int          r;
        int          g;
        logic [12:0] addr;
        r = $urandom_range(0, 99);
        if (r < 4 && ready_glyphs.size() < 40)
            load_glyph($urandom_range(1, MAX_GLYPHS - 1));
        else if (r < 16)
        begin
            g = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
            addr = (r < 8) ? 13'($urandom) : 13'(g * MAX_GLYPH_ROWS + $urandom_range(0, 15));
            put_font(addr, rand_bits());
        end
        else if (r < 26)
            put_char(KIND_CURSOR, NEWLINE_CODE, rand_pos(), rand_pos(), rand_color());
        else if (r < 30)
            push_item(KIND_NONE, noise_item());
        else if (r < 62)
            put_char(KIND_CURSOR, pick_code(), rand_pos(), rand_pos(), rand_color());
        else
            put_char(KIND_AT, pick_code(), rand_pos(), rand_pos(), rand_color());
        if ($urandom_range(0, 39) == 0)
            wait_rows_done();
    endtask

    task automatic run_random(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
            random_item();
    endtask

    initial
    begin
        trk         = new();
        idle_cycles = 0;
        items_sent  = 0;
        burst_left  = 0;
        stall_pct   = 30;
        stall_left  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_FONT;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_glyph(0);
        load_glyph(10);
        load_glyph(MAX_GLYPHS - 1);
        put_char(KIND_CURSOR, 16'd0, 16'd0, 16'd0, 32'd0);
        put_char(KIND_CURSOR, NEWLINE_CODE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        put_char(KIND_CURSOR, 16'hFFFF, 16'd0, 16'd0, 32'd0);
        put_char(KIND_CURSOR, 16'd256, 16'd0, 16'd0, 32'd0);
        put_char(KIND_CURSOR, 16'd10, 16'd0, 16'd0, 32'd0);
        put_char(KIND_CURSOR, 16'd255, 16'd0, 16'd0, 32'd0);
        put_char(KIND_AT, NEWLINE_CODE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        put_char(KIND_AT, 16'd0, 16'd0, 16'd0, 32'd0);
        put_char(KIND_AT, 16'd511, 16'd1, 16'd1, 32'h8000_0001);
        push_item(KIND_NONE, noise_item());
        put_font(13'h1FFF, 16'h0000);
        put_font(13'h0000, 16'hFFFF);
        put_char(KIND_CURSOR, 16'd0, 16'd0, 16'd0, 32'd0);
        put_char(KIND_AT, 16'd10, 16'd3, 16'd2, 32'h1234_5678);
        wait_rows_done();
        run_random(40);

        configure(1, 1, 1, 4, 32'h0);
        put_char(KIND_AT, 16'd10, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_random(50);

        configure(MAX_GLYPH_WIDTH, MAX_GLYPH_ROWS, MAX_GLYPHS, 65535, 32'hFFFF_FFFF);
        put_char(KIND_CURSOR, 16'd511, 16'd0, 16'd0, 32'd0);
        put_char(KIND_AT, 16'd511, 16'hFFFF, 16'hFFFF, 32'h0);
        put_char(KIND_AT, 16'd512, 16'hFFFF, 16'd0, 32'h5A5A_A5A5);
        run_random(50);

        // zero width and zero height
        configure(0, 0, MAX_GLYPHS, 100, 32'hCAFE_0001);
        run_random(12);
        configure(0, 5, MAX_GLYPHS, 300, 32'h0000_00FF);
        run_random(12);

        // oversized glyph, no valid glyph count
        configure(31, 31, 0, 4096, 32'h00AB_CDEF);
        put_char(KIND_AT, 16'd10, 16'd2, 16'd2, 32'h1);
        run_random(15);

        for (int p = 0; p < 4; p++)
        begin
            configure($urandom_range(1, 16), $urandom_range(1, 16),
                      $urandom_range(1, MAX_GLYPHS), $urandom_range(4, 65535), $urandom);
            run_random(45);
        end

        configure(8, 16, 256, 4096, 32'h00FF_FFFF);
        run_random(45);

        wait_rows_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (trk.errors == 0 && trk.rows_due.size() == 0)
            $display("bitmap_font_glyph_renderer_unit verification clean");
        else
            $display("bitmap_font_glyph_renderer_unit verification failed");
        $finish;
    end
endmodule

// File: files.f
rtl/bfgr_pkg.sv
rtl/bitmap_font_glyph_renderer_unit.sv
verif/bitmap_font_glyph_renderer_unit_test.sv
